// ----- sv/bia_pkg.sv -----
package bia_pkg;

	// Geometry of the free map.
	localparam int WORD_BITS = 32;
	localparam int DEFAULT_ID_COUNT = 1024;
	localparam int ID_W = 11;
	localparam int ALLOC_W = 10;
	localparam int STATUS_W = 2;

	// Word values written by the clearing pass after reset.
	localparam logic [WORD_BITS-1:0] ALL_FREE = 32'hFFFF_FFFF;
	localparam logic [WORD_BITS-1:0] WORD0_INIT = 32'hFFFF_FFFE;

	// Request codes.
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic init_wr;
		logic load;
		logic clr_addr;
		logic scan_rd;
		logic scan_eval;
		logic free_rd;
		logic free_wr;
	} bia_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic init_last;
		logic word_nz;
		logic tag_last;
		logic range_bad;
	} bia_stat_t;

	// Index of the lowest set bit of a map word; zero when the word is zero.
	function automatic logic [4:0] lowest_bit(logic [WORD_BITS-1:0] w);
		logic [4:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- sv/bitmap_id_allocator_unit.sv -----
// Bitmap id allocator: one bit per id in a map of 32-bit words, 1 meaning free.
// A request word (req_type, free_id) is taken at a rising edge where start is
// high and busy is low. req_type REQ_ALLOC grants the lowest free id; REQ_FREE
// releases free_id, and an id past the map reports ST_RANGE.
// Every request gives exactly one result word on alloc_id and status, shown for
// one cycle with done high; the receiver cannot stall, so it must take it then.
// A free in range reads its map word and writes it back with the bit set; a
// free out of range reports from the read state without touching the map.
// An allocate scans from word 0 up to the first non-empty word, or through
// the last word when the map is exhausted.
// The scan reads one map word per cycle from the single read port of the map
// memory, so an allocate takes longer the further into the map its free id lies.
// busy drops in the cycle done rises, so a new request can be taken while the
// result is shown.
// After reset a clearing pass writes one map word per cycle, leaving every
// id free except id 0; busy stays high until it ends.
module bitmap_id_allocator_unit #(
	parameter int ID_COUNT = bia_pkg::DEFAULT_ID_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [bia_pkg::ID_W-1:0]      free_id,
	output logic                          done,
	output logic [bia_pkg::ALLOC_W-1:0]   alloc_id,
	output logic [bia_pkg::STATUS_W-1:0]  status
);

	bia_pkg::bia_cmd_t cmd;
	bia_pkg::bia_stat_t stat;

	bia_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(req_type),
		.stat(stat),
		.cmd(cmd),
		.busy(busy)
	);

	bia_datapath #(
		.ID_COUNT(ID_COUNT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.free_id(free_id),
		.done(done),
		.alloc_id(alloc_id),
		.status(status)
	);

	// Every result follows a cycle in which the block was working.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in progress");

	// A failed request never carries an id.
	a_fail_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != bia_pkg::ST_OK |-> alloc_id == '0)
		else $error("failed request returned an id");

endmodule

// ----- sv/bia_ram.sv -----
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/bia_datapath.sv -----
module bia_datapath #(
	parameter int ID_COUNT = bia_pkg::DEFAULT_ID_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bia_pkg::bia_cmd_t             cmd,
	output bia_pkg::bia_stat_t            stat,
	input  logic [bia_pkg::ID_W-1:0]      free_id,
	output logic                          done,
	output logic [bia_pkg::ALLOC_W-1:0]   alloc_id,
	output logic [bia_pkg::STATUS_W-1:0]  status
);

	localparam int MAP_WORDS = ID_COUNT / bia_pkg::WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int FW = bia_pkg::ID_W - 5;
	localparam int IW = AW + 16;
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

	logic [AW-1:0] addr_q;
	logic [AW-1:0] tag_s1;
	logic [bia_pkg::ID_W-1:0] free_id_q;
	logic done_q;
	logic [bia_pkg::ALLOC_W-1:0] alloc_id_q;
	logic [bia_pkg::STATUS_W-1:0] status_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [bia_pkg::WORD_BITS-1:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [bia_pkg::WORD_BITS-1:0] ram_rdata;

	logic [FW-1:0] free_word;
	logic [16:0] free_word_ext;
	logic [AW-1:0] free_addr;
	logic [4:0] low_bit;
	logic [IW-1:0] id_ext;
	logic grant;

	// Word and bit of the id being released.
	assign free_word = free_id_q[bia_pkg::ID_W-1:5];
	assign free_word_ext = 17'(free_word);
	assign free_addr = free_word_ext[AW-1:0];

	// Lowest free bit of the word returned by the scan.
	assign low_bit = bia_pkg::lowest_bit(ram_rdata);
	assign id_ext = IW'({tag_s1, low_bit});
	assign grant = cmd.scan_eval && stat.word_nz;

	assign stat.init_last = (addr_q == LAST_WORD);
	assign stat.word_nz = (ram_rdata != '0);
	assign stat.tag_last = (tag_s1 == LAST_WORD);
	assign stat.range_bad = (32'(free_word) >= MAP_WORDS);

	// Memory port selection.
	always_comb begin
		ram_we = cmd.init_wr || cmd.free_wr || grant;
		ram_re = cmd.scan_rd || (cmd.free_rd && !stat.range_bad);
		ram_raddr = cmd.free_rd ? free_addr : addr_q;
		if (cmd.init_wr) begin
			ram_waddr = addr_q;
			ram_wdata = (addr_q == '0) ? bia_pkg::WORD0_INIT : bia_pkg::ALL_FREE;
		end else if (cmd.free_wr) begin
			ram_waddr = free_addr;
			ram_wdata = ram_rdata | (bia_pkg::WORD_BITS'(1) << free_id_q[4:0]);
		end else begin
			ram_waddr = tag_s1;
			ram_wdata = ram_rdata & ~(bia_pkg::WORD_BITS'(1) << low_bit);
		end
	end

	bia_ram #(
		.WIDTH(bia_pkg::WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Word address counter for the clearing pass and the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.clr_addr) begin
			addr_q <= '0;
		end else if (cmd.init_wr || cmd.scan_rd) begin
			addr_q <= addr_q + AW'(1);
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.scan_eval && (stat.word_nz || stat.tag_last))
				|| (cmd.free_rd && stat.range_bad) || cmd.free_wr;
		end
	end

	// Request capture, scan tag and result word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			free_id_q <= free_id;
		end
		if (cmd.scan_rd) begin
			tag_s1 <= addr_q;
		end
		if (cmd.scan_eval) begin
			alloc_id_q <= stat.word_nz ? id_ext[bia_pkg::ALLOC_W-1:0] : '0;
			status_q <= stat.word_nz ? bia_pkg::ST_OK : bia_pkg::ST_EMPTY;
		end else if (cmd.free_rd) begin
			alloc_id_q <= '0;
			status_q <= bia_pkg::ST_RANGE;
		end else if (cmd.free_wr) begin
			alloc_id_q <= '0;
			status_q <= bia_pkg::ST_OK;
		end
	end

	assign done = done_q;
	assign alloc_id = alloc_id_q;
	assign status = status_q;

	// A map word is never written and read at the same address in one cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && ram_waddr == ram_raddr))
		else $error("map word written and read in the same cycle");

	// A grant clears exactly one bit of the scanned word.
	a_one_bit_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		grant |-> $countones(ram_rdata ^ ram_wdata) == 1)
		else $error("grant did not clear exactly one bit");

endmodule

// ----- sv/bia_ctrl.sv -----
module bia_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               req_type,
	input  bia_pkg::bia_stat_t stat,
	output bia_pkg::bia_cmd_t  cmd,
	output logic               busy
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN0,
		S_SCAN,
		S_FREE_RD,
		S_FREE_WR
	} state_t;

	state_t state_q;

	// Commands decoded from the current state.
	always_comb begin
		cmd = '0;
		case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
			end
			S_IDLE: begin
				cmd.load = start;
				cmd.clr_addr = start;
			end
			S_SCAN0: begin
				cmd.scan_rd = 1'b1;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.scan_eval = 1'b1;
			end
			S_FREE_RD: begin
				cmd.free_rd = 1'b1;
			end
			S_FREE_WR: begin
				cmd.free_wr = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			case (state_q)
				S_INIT: begin
					if (stat.init_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= (req_type == bia_pkg::REQ_FREE) ? S_FREE_RD : S_SCAN0;
					end
				end
				S_SCAN0: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (stat.word_nz || stat.tag_last) begin
						state_q <= S_IDLE;
					end
				end
				S_FREE_RD: begin
					state_q <= stat.range_bad ? S_IDLE : S_FREE_WR;
				end
				S_FREE_WR: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The clearing pass runs only once after reset.
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_INIT |=> state_q != S_INIT)
		else $error("clearing pass entered again");

	// A free write always follows an in-range free read.
	a_free_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FREE_WR |-> $past(state_q) == S_FREE_RD && !$past(stat.range_bad))
		else $error("free write without a valid read");

endmodule

// ----- tb/sv/bitmap_id_allocator_unit_test.sv -----
module bitmap_id_allocator_unit_test;

	import bia_pkg::*;

	localparam int MAP_WORDS = DEFAULT_ID_COUNT / WORD_BITS;
	localparam int ID_LIMIT = MAP_WORDS * WORD_BITS;
	localparam int RANDOM_ITEMS = 1100;
	localparam int MAX_GAP = 40;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 40;

	// One result word as the block shows it on done.
	typedef struct packed {
		logic [ALLOC_W-1:0]  alloc_id;
		logic [STATUS_W-1:0] status;
	} grant_word_t;

	// Keeps its own copy of the free map, works out the result word of each
	// accepted request and compares the block's result words against them in order.
	class id_grant_checker;
		logic [WORD_BITS-1:0] free_map [MAP_WORDS];
		grant_word_t pending_results [$];
		int mismatches;

		function new();
			foreach (free_map[w]) begin
				free_map[w] = ALL_FREE;
			end
			free_map[0] = WORD0_INIT;
			mismatches = 0;
		endfunction

		// Applies one request to the map and returns the result word it gives.
		function grant_word_t apply_request(logic req, logic [ID_W-1:0] id);
			grant_word_t res;
			logic [WORD_BITS-1:0] lowest;
			int bit_idx;
			res.alloc_id = '0;
			res.status = ST_OK;
			if (req == REQ_ALLOC) begin
				res.status = ST_EMPTY;
				for (int w = 0; w < MAP_WORDS; w++) begin
					if (res.status == ST_EMPTY && free_map[w] != '0) begin
						// Isolate the lowest set bit; its log2 is the bit index.
						lowest = free_map[w] & (~free_map[w] + 1'b1);
						bit_idx = $clog2(lowest);
						free_map[w] = free_map[w] & ~lowest;
						res.alloc_id = ALLOC_W'(w * WORD_BITS + bit_idx);
						res.status = ST_OK;
					end
				end
			end else if (int'(id) / WORD_BITS >= MAP_WORDS) begin
				res.status = ST_RANGE;
			end else begin
				free_map[int'(id) / WORD_BITS][int'(id) % WORD_BITS] = 1'b1;
			end
			return res;
		endfunction

		function void note_request(logic req, logic [ID_W-1:0] id);
			pending_results.push_back(apply_request(req, id));
		endfunction

		function void check_result(logic [ALLOC_W-1:0] got_id, logic [STATUS_W-1:0] got_status);
			grant_word_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result word with nothing expected, alloc_id %0d status %0d",
					$time, got_id, got_status);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (got_id !== want.alloc_id) begin
				$display("%0t: alloc_id mismatch, expected %0d, actual %0d",
					$time, want.alloc_id, got_id);
				mismatches++;
			end
			if (got_status !== want.status) begin
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, want.status, got_status);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function int free_count();
			int n;
			n = 0;
			foreach (free_map[w]) begin
				n += $countones(free_map[w]);
			end
			return n;
		endfunction

		// Random in-range id whose map bit equals want_free, if there is one.
		function logic [ID_W-1:0] pick_id(bit want_free);
			int base;
			int id;
			base = $urandom_range(ID_LIMIT - 1);
			for (int k = 0; k < ID_LIMIT; k++) begin
				id = (base + k) % ID_LIMIT;
				if (free_map[id / WORD_BITS][id % WORD_BITS] == want_free) begin
					return ID_W'(id);
				end
			end
			return ID_W'(base);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic req_type = REQ_ALLOC;
	logic [ID_W-1:0] free_id = '0;
	logic busy;
	logic done;
	logic [ALLOC_W-1:0] alloc_id;
	logic [STATUS_W-1:0] status;

	id_grant_checker grants = new();
	int sender_idle_pct = 13;
	int stall_cycles = 0;

	bitmap_id_allocator_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.free_id  (free_id),
		.done     (done),
		.alloc_id (alloc_id),
		.status   (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result words are shown for one cycle only, so every done is checked.
	always @(posedge clk) begin
		if (arst_n && done) begin
			grants.check_result(alloc_id, status);
		end
	end

	// Watchdog: ends the run when neither side moves a word for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL bitmap_id_allocator_unit");
			$finish;
		end
	end

	// Presents one request word after a random gap and notes it once accepted.
	task automatic send_word(input logic req, input logic [ID_W-1:0] id);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= req;
		free_id <= id;
		do @(posedge clk); while (busy !== 1'b0);
		grants.note_request(req, id);
	endtask

	// Holds the sender off until every result word has come back.
	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (grants.outstanding() != 0);
		@(posedge clk);
	endtask

	initial begin
		int third;
		int r;
		bit filling;
		logic req;
		logic [ID_W-1:0] id;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words: id 0 release and reuse, repeated and edge frees,
		// both ends of the out-of-range band, and ignored free_id on allocate.
		send_word(REQ_ALLOC, ID_W'(0));
		send_word(REQ_ALLOC, ID_W'(2047));
		send_word(REQ_FREE, ID_W'(0));
		send_word(REQ_ALLOC, ID_W'(0));
		send_word(REQ_FREE, ID_W'(1));
		send_word(REQ_FREE, ID_W'(1));
		send_word(REQ_FREE, ID_W'(1023));
		send_word(REQ_FREE, ID_W'(1024));
		send_word(REQ_FREE, ID_W'(2047));
		send_word(REQ_ALLOC, ID_W'(1365));
		send_word(REQ_FREE, ID_W'(682));
		send_word(REQ_FREE, ID_W'(2));
		send_word(REQ_ALLOC, ID_W'(682));
		send_word(REQ_ALLOC, ID_W'(1365));
		send_word(REQ_FREE, ID_W'(31));
		send_word(REQ_FREE, ID_W'(32));
		send_word(REQ_FREE, ID_W'(1535));
		send_word(REQ_ALLOC, ID_W'(1024));

		// Random words: first fill the map until it runs dry, with a little
		// noise, then churn around the exhausted point with real releases.
		third = RANDOM_ITEMS / 3;
		filling = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == third) begin
				wait_drained();
				sender_idle_pct = 59;
			end else if (i == 2 * third) begin
				wait_drained();
				sender_idle_pct = 0;
			end
			if (filling && grants.free_count() == 0) begin
				filling = 1'b0;
			end
			r = $urandom_range(99);
			req = REQ_FREE;
			id = ID_W'($urandom_range(2047));
			if (filling) begin
				if (r < 98) begin
					req = REQ_ALLOC;
				end else if (r == 98) begin
					id = ID_W'(ID_LIMIT + $urandom_range(ID_LIMIT - 1));
				end else begin
					id = grants.pick_id(1'b1);
				end
			end else if ($urandom_range(1) == 0) begin
				req = REQ_ALLOC;
			end else if (r < 70) begin
				id = grants.pick_id(1'b0);
			end else if (r < 85) begin
				id = ID_W'(ID_LIMIT + $urandom_range(ID_LIMIT - 1));
			end else begin
				id = grants.pick_id(1'b1);
			end
			send_word(req, id);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (grants.mismatches == 0 && grants.outstanding() == 0) begin
			$display("PASS bitmap_id_allocator_unit");
		end else begin
			$display("FAIL bitmap_id_allocator_unit");
		end
		$finish;
	end

endmodule
